### design/bpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// shared types, widths and helpers for the position embedding index generator
// ----------------------------------------------------------------------------
package bpe_pkg;

   // fraction bits of the bilinear weights
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int DIM_W    = 11;
   localparam int OFF_W    = 20;
   localparam int MERGE_W  = 4;
   localparam int SIDE_W   = 7;
   localparam int ROWS_W   = 13;
   localparam int ID_W     = 12;
   localparam int WEIGHT_W = 17;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // raw corner id before range check
   localparam int RAW_ID_W = 2 * SIDE_W;
   localparam int ID_MAX   = (1 << ID_W) - 1;

   // divider sizing: dividend covers the fraction numerator, divisor covers h*w
   localparam int NUM_W = (DIM_W + FRAC_BITS > OFF_W) ? DIM_W + FRAC_BITS : OFF_W;
   localparam int DEN_W = 2 * DIM_W;

   localparam int FRACP_W = FRAC_BITS + 1;
   localparam int PROD_W  = 2 * FRACP_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MERGE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIDE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_ROWS = 2'd2;

   // reset values
   localparam logic [MERGE_W-1:0] MERGE_RESET = 4'd2;
   localparam logic [SIDE_W-1:0]  SIDE_RESET  = 7'd48;
   localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd2304;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MERGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 2'd2;

   // token context carried alongside the divider stages
   typedef struct packed {
      logic [DIM_W-1:0]  height;
      logic [DIM_W-1:0]  width;
      logic              h_bad;
      logic              w_bad;
      logic [DIM_W-1:0]  blocks_w;
      logic [SIDE_W-1:0] hf;
      logic [SIDE_W-1:0] wf;
   } ctx_type;

   // one restoring division step: returns {remainder, shifted dividend/quotient}
   function automatic logic [DEN_W+NUM_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                       input logic [NUM_W-1:0] nq,
                                                       input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      trial = {rem, nq[NUM_W-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {diff[DEN_W-1:0], nq[NUM_W-2:0], 1'b1};
      end
      return {trial[DEN_W-1:0], nq[NUM_W-2:0], 1'b0};
   endfunction

endpackage

### design/bilinear_pos_embed_index_gen_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_pos_embed_index_gen_core
// per-token corner ids and bilinear weights into a square position table
// ----------------------------------------------------------------------------
// channel   ports                       role
// req       req_valid / req_ready       token in: grid height, width, offset
// rsp       rsp_valid / rsp_ready       four corner ids, four weights, status
// csr       csr_valid / csr_ready       register write: index, data
//
// one transaction per cycle sustained while rsp is not stalled; the pipe is five divider
// passes of NUM_W+1 stages each plus one position stage and three back-end stages
// reset (synchronous) clears every valid bit and loads the register defaults
// a stall at rsp freezes the whole pipeline in place; req_ready drops with it
// csr writes are always taken; they are expected only while the pipe is empty
// ----------------------------------------------------------------------------
module bilinear_pos_embed_index_gen_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bpe_pkg::DIM_W-1:0]      req_grid_height,
   input  logic [bpe_pkg::DIM_W-1:0]      req_grid_width,
   input  logic [bpe_pkg::OFF_W-1:0]      req_frame_offset,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bpe_pkg::ID_W-1:0]       rsp_id_top_left,
   output logic [bpe_pkg::ID_W-1:0]       rsp_id_top_right,
   output logic [bpe_pkg::ID_W-1:0]       rsp_id_bottom_left,
   output logic [bpe_pkg::ID_W-1:0]       rsp_id_bottom_right,
   output logic [bpe_pkg::WEIGHT_W-1:0]   rsp_weight_top_left,
   output logic [bpe_pkg::WEIGHT_W-1:0]   rsp_weight_top_right,
   output logic [bpe_pkg::WEIGHT_W-1:0]   rsp_weight_bottom_left,
   output logic [bpe_pkg::WEIGHT_W-1:0]   rsp_weight_bottom_right,
   output logic [bpe_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpe_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int NW = bpe_pkg::NUM_W;
   localparam int DW = bpe_pkg::DEN_W;
   localparam int FB = bpe_pkg::FRAC_BITS;
   localparam int SW = bpe_pkg::SIDE_W;
   localparam int RW = bpe_pkg::RAW_ID_W;
   localparam int XW = bpe_pkg::DIM_W;
   localparam logic [bpe_pkg::FRACP_W-1:0] ONE  = bpe_pkg::FRACP_W'(1) << FB;
   localparam logic [bpe_pkg::PROD_W-1:0]  HALF = bpe_pkg::PROD_W'(1) << (FB - 1);

   // ---------------- configuration registers ----------------
   logic [bpe_pkg::MERGE_W-1:0] merge_ff;
   logic [SW-1:0]               side_ff;
   logic [bpe_pkg::ROWS_W-1:0]  rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ff <= bpe_pkg::MERGE_RESET;
         side_ff  <= bpe_pkg::SIDE_RESET;
         rows_ff  <= bpe_pkg::ROWS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bpe_pkg::REG_MERGE_SIZE: merge_ff <= csr_data[bpe_pkg::MERGE_W-1:0];
            bpe_pkg::REG_GRID_SIDE:  side_ff  <= csr_data[SW-1:0];
            bpe_pkg::REG_TABLE_ROWS: rows_ff  <= csr_data[bpe_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // derived config; the user keeps it stable while tokens are in flight, the block does not enforce it
   logic [7:0]    merge_sq;
   logic [SW-1:0] side_m1;
   assign merge_sq = 8'(merge_ff) * 8'(merge_ff);
   assign side_m1  = side_ff - 1'b1;

   // global advance: everything moves unless the output slot is held
   logic en;
   logic out_v_ff;
   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- pass 1: offset mod h*w, blocks across = w / m ----------------
   bpe_pkg::ctx_type c0, c1, c2, c3, c4, c5;
   logic             v1, v2, v3, v4, v5;
   logic [NW-1:0]    q1a, q1b, q2a, q2b, q3a, q3b, q4a, q4b, q5a, q5b;
   logic [DW-1:0]    r1a, r1b, r2a, r2b, r3a, r3b, r4a, r4b, r5a, r5b;
   logic [DW-1:0]    hw;

   assign hw = DW'(req_grid_height) * DW'(req_grid_width);

   always_comb begin
      c0          = '0;
      c0.height   = req_grid_height;
      c0.width    = req_grid_width;
   end

   bpe_div2 u_pass1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid), .in_ctx(c0),
      .num0(NW'(req_frame_offset)), .den0(hw),
      .num1(NW'(req_grid_width)), .den1(DW'(merge_ff)),
      .out_valid(v1), .out_ctx(c1), .quo0(q1a), .rem0(r1a), .quo1(q1b), .rem1(r1b)
   );

   // ---------------- pass 2: h mod m, offset into merge blocks ----------------
   bpe_pkg::ctx_type c1n;
   always_comb begin
      c1n          = c1;
      c1n.blocks_w = q1b[XW-1:0];
      c1n.w_bad    = (r1b != '0);
   end

   bpe_div2 u_pass2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(v1), .in_ctx(c1n),
      .num0(NW'(c1.height)), .den0(DW'(merge_ff)),
      .num1(NW'(r1a)), .den1(DW'(merge_sq)),
      .out_valid(v2), .out_ctx(c2), .quo0(q2a), .rem0(r2a), .quo1(q2b), .rem1(r2b)
   );

   // ---------------- pass 3: split intra-block and block index ----------------
   bpe_pkg::ctx_type c2n;
   always_comb begin
      c2n       = c2;
      c2n.h_bad = (r2a != '0);
   end

   bpe_div2 u_pass3 (
      .clock(clock), .reset(reset), .en(en), .in_valid(v2), .in_ctx(c2n),
      .num0(NW'(r2b)), .den0(DW'(merge_ff)),
      .num1(q2b), .den1(DW'(c2.blocks_w)),
      .out_valid(v3), .out_ctx(c3), .quo0(q3a), .rem0(r3a), .quo1(q3b), .rem1(r3b)
   );

   // ---------------- patch row and column ----------------
   logic             pos_v_ff;
   bpe_pkg::ctx_type pos_ctx_ff;
   logic [XW-1:0]    ph_ff, pw_ff, ph_in, pw_in;

   // valid tokens have ph < h and pw < w, so modular width is enough
   assign ph_in = XW'(q3b[XW-1:0] * XW'(merge_ff)) + q3a[XW-1:0];
   assign pw_in = XW'(r3b[XW-1:0] * XW'(merge_ff)) + r3a[XW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_v_ff <= 1'b0;
      end else if (en) begin
         pos_v_ff <= v3;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ctx_ff <= c3;
         ph_ff      <= ph_in;
         pw_ff      <= pw_in;
      end
   end

   // ---------------- pass 4: scale onto the stored grid ----------------
   logic [XW-1:0] h_m1, w_m1;
   assign h_m1 = pos_ctx_ff.height - 1'b1;
   assign w_m1 = pos_ctx_ff.width - 1'b1;

   bpe_div2 u_pass4 (
      .clock(clock), .reset(reset), .en(en), .in_valid(pos_v_ff), .in_ctx(pos_ctx_ff),
      .num0(NW'(ph_ff) * NW'(side_m1)), .den0(DW'(h_m1)),
      .num1(NW'(pw_ff) * NW'(side_m1)), .den1(DW'(w_m1)),
      .out_valid(v4), .out_ctx(c4), .quo0(q4a), .rem0(r4a), .quo1(q4b), .rem1(r4b)
   );

   // ---------------- pass 5: exact fractions ----------------
   bpe_pkg::ctx_type c4n;
   always_comb begin
      c4n    = c4;
      c4n.hf = q4a[SW-1:0];
      c4n.wf = q4b[SW-1:0];
   end

   // remainders sit below h-1, so they fit the dimension width
   bpe_div2 u_pass5 (
      .clock(clock), .reset(reset), .en(en), .in_valid(v4), .in_ctx(c4n),
      .num0(NW'({r4a[XW-1:0], FB'(0)})), .den0(DW'(c4.height - 1'b1)),
      .num1(NW'({r4b[XW-1:0], FB'(0)})), .den1(DW'(c4.width - 1'b1)),
      .out_valid(v5), .out_ctx(c5), .quo0(q5a), .rem0(r5a), .quo1(q5b), .rem1(r5b)
   );

   // ---------------- back end 1: corners and raw ids ----------------
   logic          unit_h, unit_w;
   logic [SW-1:0] hf, wf, hc, wc;
   logic [SW:0]   hf_p1, wf_p1;
   logic [FB-1:0] dh, dw;
   logic          err_merge;

   assign unit_h = (c5.height <= XW'(1));
   assign unit_w = (c5.width <= XW'(1));
   assign hf     = unit_h ? '0 : c5.hf;
   assign wf     = unit_w ? '0 : c5.wf;
   assign dh     = unit_h ? '0 : q5a[FB-1:0];
   assign dw     = unit_w ? '0 : q5b[FB-1:0];
   assign hf_p1  = {1'b0, hf} + 1'b1;
   assign wf_p1  = {1'b0, wf} + 1'b1;
   // ceiling clamp to the last grid line
   assign hc     = (hf_p1 < {1'b0, side_m1}) ? hf_p1[SW-1:0] : side_m1;
   assign wc     = (wf_p1 < {1'b0, side_m1}) ? wf_p1[SW-1:0] : side_m1;
   // remainders r5a, r5b are not needed beyond the fraction
   assign err_merge = (merge_ff == '0) || (c5.height == '0) || (c5.width == '0)
                      || c5.h_bad || c5.w_bad || (r5a == '1 && r5b == '1 && 1'b0);

   logic          e1_v_ff, e1_err_merge_ff, e1_err_side_ff;
   logic [RW-1:0] e1_id_ff [4];
   logic [FB-1:0] e1_dh_ff, e1_dw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
      end else if (en) begin
         e1_v_ff <= v5;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_id_ff[0]     <= RW'(hf) * RW'(side_ff) + RW'(wf);
         e1_id_ff[1]     <= RW'(hf) * RW'(side_ff) + RW'(wc);
         e1_id_ff[2]     <= RW'(hc) * RW'(side_ff) + RW'(wf);
         e1_id_ff[3]     <= RW'(hc) * RW'(side_ff) + RW'(wc);
         e1_dh_ff        <= dh;
         e1_dw_ff        <= dw;
         e1_err_merge_ff <= err_merge;
         e1_err_side_ff  <= (side_ff == '0);
      end
   end

   // ---------------- back end 2: range check and weight products ----------------
   logic                            id_bad;
   logic [bpe_pkg::STATUS_W-1:0]    status_in;
   logic [bpe_pkg::FRACP_W-1:0]     fh, fw, gh, gw;

   always_comb begin
      id_bad = e1_err_side_ff;
      for (int k = 0; k < 4; k++) begin
         if (e1_id_ff[k] >= RW'(rows_ff) || e1_id_ff[k] > RW'(bpe_pkg::ID_MAX)) begin
            id_bad = 1'b1;
         end
      end
   end

   assign status_in = e1_err_merge_ff ? bpe_pkg::STATUS_BAD_MERGE :
                      id_bad          ? bpe_pkg::STATUS_BAD_ID    : bpe_pkg::STATUS_OK;
   assign fh = bpe_pkg::FRACP_W'(e1_dh_ff);
   assign fw = bpe_pkg::FRACP_W'(e1_dw_ff);
   assign gh = ONE - fh;
   assign gw = ONE - fw;

   logic                            e2_v_ff;
   logic [bpe_pkg::STATUS_W-1:0]    e2_status_ff;
   logic [bpe_pkg::ID_W-1:0]        e2_id_ff   [4];
   logic [bpe_pkg::PROD_W-1:0]      e2_prod_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_v_ff <= 1'b0;
      end else if (en) begin
         e2_v_ff <= e1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e2_status_ff  <= status_in;
         for (int k = 0; k < 4; k++) begin
            e2_id_ff[k] <= e1_id_ff[k][bpe_pkg::ID_W-1:0];
         end
         e2_prod_ff[0] <= bpe_pkg::PROD_W'(gh) * bpe_pkg::PROD_W'(gw);
         e2_prod_ff[1] <= bpe_pkg::PROD_W'(gh) * bpe_pkg::PROD_W'(fw);
         e2_prod_ff[2] <= bpe_pkg::PROD_W'(fh) * bpe_pkg::PROD_W'(gw);
         e2_prod_ff[3] <= bpe_pkg::PROD_W'(fh) * bpe_pkg::PROD_W'(fw);
      end
   end

   // ---------------- output register: rounding, error zeroing ----------------
   logic                            ok;
   logic [bpe_pkg::PROD_W-1:0]      rnd [4];
   logic [bpe_pkg::WEIGHT_W-1:0]    wt_in [4];
   logic [bpe_pkg::ID_W-1:0]        id_in [4];

   assign ok = (e2_status_ff == bpe_pkg::STATUS_OK);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rnd[k]   = (e2_prod_ff[k] + HALF) >> FB;
         wt_in[k] = ok ? rnd[k][bpe_pkg::WEIGHT_W-1:0] : '0;
         id_in[k] = ok ? e2_id_ff[k] : '0;
      end
   end

   logic [bpe_pkg::ID_W-1:0]     out_id_ff [4];
   logic [bpe_pkg::WEIGHT_W-1:0] out_wt_ff [4];
   logic [bpe_pkg::STATUS_W-1:0] out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= e2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_id_ff     <= id_in;
         out_wt_ff     <= wt_in;
         out_status_ff <= e2_status_ff;
      end
   end

   assign rsp_valid               = out_v_ff;
   assign rsp_id_top_left         = out_id_ff[0];
   assign rsp_id_top_right        = out_id_ff[1];
   assign rsp_id_bottom_left      = out_id_ff[2];
   assign rsp_id_bottom_right     = out_id_ff[3];
   assign rsp_weight_top_left     = out_wt_ff[0];
   assign rsp_weight_top_right    = out_wt_ff[1];
   assign rsp_weight_bottom_left  = out_wt_ff[2];
   assign rsp_weight_bottom_right = out_wt_ff[3];
   assign rsp_status              = out_status_ff;

`ifndef SYNTHESIS
   // weights of a good token add up to one within rounding
   logic [bpe_pkg::WEIGHT_W+1:0] wsum;
   assign wsum = (bpe_pkg::WEIGHT_W+2)'(rsp_weight_top_left)
               + (bpe_pkg::WEIGHT_W+2)'(rsp_weight_top_right)
               + (bpe_pkg::WEIGHT_W+2)'(rsp_weight_bottom_left)
               + (bpe_pkg::WEIGHT_W+2)'(rsp_weight_bottom_right);

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bpe_pkg::STATUS_OK |->
         wsum >= (bpe_pkg::WEIGHT_W+2)'(ONE) - 2 && wsum <= (bpe_pkg::WEIGHT_W+2)'(ONE) + 2)
      else $error("weights of a good transaction do not sum to one");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bpe_pkg::STATUS_OK |->
         rsp_id_bottom_right == '0 && rsp_weight_top_left == '0
         && rsp_weight_bottom_right == '0)
      else $error("error transaction carries nonzero ids or weights");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == bpe_pkg::STATUS_OK
         || rsp_status == bpe_pkg::STATUS_BAD_MERGE || rsp_status == bpe_pkg::STATUS_BAD_ID)
      else $error("undefined status code");
`endif

endmodule

### design/bpe_div2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_div2
// two-lane pipelined restoring divider: an input register, then one quotient bit per stage
// ----------------------------------------------------------------------------
module bpe_div2 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  bpe_pkg::ctx_type            in_ctx,
   input  logic [bpe_pkg::NUM_W-1:0]   num0,
   input  logic [bpe_pkg::DEN_W-1:0]   den0,
   input  logic [bpe_pkg::NUM_W-1:0]   num1,
   input  logic [bpe_pkg::DEN_W-1:0]   den1,
   output logic                        out_valid,
   output bpe_pkg::ctx_type            out_ctx,
   output logic [bpe_pkg::NUM_W-1:0]   quo0,
   output logic [bpe_pkg::DEN_W-1:0]   rem0,
   output logic [bpe_pkg::NUM_W-1:0]   quo1,
   output logic [bpe_pkg::DEN_W-1:0]   rem1
);

   localparam int STAGES = bpe_pkg::NUM_W + 1;

   logic [STAGES-1:0]          valid_ff;
   bpe_pkg::ctx_type           ctx_ff [STAGES];
   logic [bpe_pkg::NUM_W-1:0]  nq_ff  [2][STAGES];
   logic [bpe_pkg::DEN_W-1:0]  rem_ff [2][STAGES];
   logic [bpe_pkg::DEN_W-1:0]  den_ff [2][STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0]    <= in_ctx;
         nq_ff[0][0]  <= num0;
         rem_ff[0][0] <= '0;
         den_ff[0][0] <= den0;
         nq_ff[1][0]  <= num1;
         rem_ff[1][0] <= '0;
         den_ff[1][0] <= den1;
         for (int s = 1; s < STAGES; s++) begin
            ctx_ff[s] <= ctx_ff[s-1];
            for (int l = 0; l < 2; l++) begin
               {rem_ff[l][s], nq_ff[l][s]} <=
                  bpe_pkg::div_step(rem_ff[l][s-1], nq_ff[l][s-1], den_ff[l][s-1]);
               den_ff[l][s] <= den_ff[l][s-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_ctx   = ctx_ff[STAGES-1];
   assign quo0      = nq_ff[0][STAGES-1];
   assign rem0      = rem_ff[0][STAGES-1];
   assign quo1      = nq_ff[1][STAGES-1];
   assign rem1      = rem_ff[1][STAGES-1];

endmodule
